// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property holds on every clock edge out of reset
`define CTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// expression never true out of reset
`define CTS_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define CTS_ASSERT(lbl, clk, rstn, prop, msg)
`define CTS_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== hw/rtl/ctsched_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsched_pkg
// Types and codes shared by the tick scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsched_pkg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_RR_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IO_MAX  = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] run_time;
        logic [15:0] block_prob;
        logic [15:0] block_roll;
        logic [15:0] split_roll;
        logic [15:0] io_roll;
    } t_item;

    typedef struct packed {
        logic        load_error;
        logic        cpu_was_busy;
        logic        io_was_busy;
        logic        done_valid;
        logic [5:0]  done_id;
        logic [31:0] done_time;
        logic [15:0] done_dispatches;
        logic [15:0] done_io_blocks;
        logic [23:0] done_io_time;
        logic [31:0] tick_now;
        logic        all_finished;
    } t_res;

    // one entry of the process table
    typedef struct packed {
        logic [15:0] cpu_left;
        logic [15:0] block_chance;
        logic [7:0]  io_left;
        logic [15:0] dispatch_count;
        logic [15:0] io_block_count;
        logic [23:0] io_total;
    } t_proc;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_LOAD,
        OP_DISP,
        OP_RUNRD,
        OP_CLATCH,
        OP_CFIX,
        OP_CEXEC,
        OP_IOCHK,
        OP_IOPOP,
        OP_IOSRD,
        OP_ILATCH,
        OP_IFIX,
        OP_ISERVE,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic run_valid;
        logic ready_nz;
        logic io_nz;
        logic io_valid;
        logic io_skip;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/ctsched_stream_if.sv =====
// ----------------------------------------------------------------------------
// ctsched_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctsched_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cpu_io_tick_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// cpu_io_tick_scheduler_top
// Tick-driven cpu and io scheduler with round-robin or fcfs dispatch.
// ----------------------------------------------------------------------------
// i_item carries one request: a load adds a process to the ready queue, a
// tick runs the cpu step then the io step. o_res returns exactly one result
// per request. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// by the user only while the block is idle; the block does not enforce it.
// A tick may need a remainder for the quantum split on a blocking dispatch
// and for the io service time; both go through one bit-serial remainder
// unit. Table reads go through a registered ram port.
// One request is worked on at a time; a new one is accepted as soon as the
// previous one has reached the output register.
// If the receiver stalls, the finished result waits in the output register
// and the next request stops just before its own result is written.
// Reset empties both queues, clears the running and io slots, sets the tick
// to one and restores the register defaults; tables need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_io_tick_scheduler_top #(
    parameter int MAX_PROCS = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    ctsched_stream_if.sink                          i_item,
    ctsched_stream_if.source                        o_res,
    input  wire logic                               i_cfg_we,
    input  wire logic [ctsched_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ctsched_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ctsched_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_item.ready = in_ready;

    ctsched_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_item.valid),
        .o_in_ready(in_ready), .i_stat(stat), .o_cmd(cmd)
    );

    ctsched_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_item(i_item.data), .i_cmd(cmd), .o_stat(stat),
        .o_res(o_res.data), .o_res_valid(o_res.valid), .i_res_ready(o_res.ready)
    );
endmodule

`default_nettype wire

// ===== hw/rtl/ctsched_ram.sv =====
// ----------------------------------------------------------------------------
// ctsched_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== hw/rtl/ctsched_div.sv =====
// ----------------------------------------------------------------------------
// ctsched_div
// Restoring remainder unit for 16-bit operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsched_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_busy,
    output logic      [15:0] o_rem
);
    logic [4:0]  r_cnt;
    logic [15:0] r_dvd;
    logic [15:0] r_dsr;
    logic [15:0] r_rem;
    logic [16:0] trial;

    assign trial  = {r_rem, r_dvd[15]};
    assign o_busy = (r_cnt != 5'd0);
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 5'd0;
        end else if (i_start) begin
            r_cnt <= 5'd16;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= 16'd0;
        end else if (o_busy) begin
            r_dvd <= {r_dvd[14:0], 1'b0};
            if (trial >= {1'b0, r_dsr}) begin
                r_rem <= 16'(trial - {1'b0, r_dsr});
            end else begin
                r_rem <= trial[15:0];
            end
        end
    end
endmodule

`default_nettype wire

// ===== hw/rtl/ctsched_dp.sv =====
// ----------------------------------------------------------------------------
// ctsched_dp
// Scheduler datapath: process table, ready and io queues, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ctsched_dp #(
    parameter int MAX_PROCS = 64
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [ctsched_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [ctsched_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire ctsched_pkg::t_item                   i_item,
    input  wire ctsched_pkg::t_cmd                    i_cmd,
    output ctsched_pkg::t_stat                        o_stat,
    output ctsched_pkg::t_res                         o_res,
    output logic                                      o_res_valid,
    input  wire logic                                 i_res_ready
);
    import ctsched_pkg::*;

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = AW + 1;
    localparam int HW = CW + 2;
    localparam logic [CW-1:0] N_PROCS = CW'(MAX_PROCS);

    function automatic logic [AW-1:0] f_wrap(input logic [CW-1:0] s);
        logic [CW-1:0] t;
        t = (s >= N_PROCS) ? s - N_PROCS : s;
        return t[AW-1:0];
    endfunction

    // configuration
    logic       r_rr;
    logic [7:0] r_quantum;
    logic [7:0] r_io_max;

    // control state
    logic [AW-1:0] r_rhead, r_ihead;
    logic [CW-1:0] r_rcnt, r_icnt, r_next_id;
    logic          r_run_valid, r_io_valid;
    logic [AW-1:0] r_run_slot, r_io_slot;
    logic          r_will_block, r_io_wake, r_io_idle;
    logic          r_disp, r_io_new, r_need;
    logic [31:0]   r_tick;
    logic          r_res_valid;

    // payload
    t_item       r_item;
    t_proc       r_pr;
    logic [15:0] r_budget;
    t_res        r_work;
    t_res        r_res;

    // memories
    logic                 tab_we;
    logic [AW-1:0]        tab_wa, tab_ra;
    logic [$bits(t_proc)-1:0] tab_wd, tab_rd;
    t_proc                tab_p;
    logic                 rq_we, iq_we;
    logic [AW-1:0]        rq_wa, iq_wa, rq_wd, iq_wd, rq_rd, iq_rd;

    // divider
    logic        div_start, div_busy;
    logic [15:0] div_dvd, div_dsr, div_rem;

    // helpers
    logic [7:0]  q8, m8;
    logic [15:0] bud;
    logic        blk, load_full;
    logic        cx_left_nz, cx_exp, cx_io, cx_rq;
    logic [7:0]  sv_left, io_t;
    logic        sv_fin, all_fin;
    t_proc       load_rec, cexec_rec, serve_rec, clatch_rec;
    t_res        fin_res;
    logic [HW-1:0] procs_held;

    assign tab_p     = t_proc'(tab_rd);
    assign q8        = (r_quantum == 8'd0) ? 8'd1 : r_quantum;
    assign m8        = (r_io_max == 8'd0) ? 8'd1 : r_io_max;
    assign load_full = (r_next_id >= N_PROCS);
    assign all_fin   = (r_rcnt == '0) && (r_icnt == '0) && !r_run_valid && !r_io_valid;

    always_comb begin
        bud = tab_p.cpu_left;
        if (r_rr && (bud > {8'd0, q8})) begin
            bud = {8'd0, q8};
        end
        blk = (tab_p.cpu_left >= 16'd2) && (r_item.block_roll < tab_p.block_chance)
              && (bud != 16'd0);
    end

    assign cx_left_nz = (r_pr.cpu_left != 16'd0);
    assign cx_exp     = (r_budget <= 16'd1);
    assign cx_io      = cx_left_nz && r_will_block && cx_exp;
    assign cx_rq      = cx_left_nz && !r_will_block && r_rr && cx_exp;
    assign sv_left    = (r_pr.io_left != 8'd0) ? r_pr.io_left - 8'd1 : 8'd0;
    assign sv_fin     = (sv_left == 8'd0);
    assign io_t       = r_need ? div_rem[7:0] + 8'd1 : 8'd1;

    always_comb begin
        load_rec                = '0;
        load_rec.cpu_left       = r_item.run_time;
        load_rec.block_chance   = r_item.block_prob;
        cexec_rec               = r_pr;
        cexec_rec.cpu_left      = cx_left_nz ? r_pr.cpu_left - 16'd1 : r_pr.cpu_left;
        serve_rec               = r_pr;
        serve_rec.io_left       = sv_left;
        clatch_rec              = tab_p;
        if (r_disp) begin
            clatch_rec.dispatch_count = tab_p.dispatch_count + 16'd1;
        end
        fin_res                 = r_work;
        fin_res.tick_now        = r_tick;
        fin_res.all_finished    = all_fin;
    end

    assign rq_wa = f_wrap(CW'(r_rhead) + r_rcnt);
    assign iq_wa = f_wrap(CW'(r_ihead) + r_icnt);
    assign iq_wd = r_run_slot;
    assign iq_we = (i_cmd.op == OP_CEXEC) && cx_io;

    always_comb begin
        tab_we = 1'b0;
        tab_wa = r_run_slot;
        tab_wd = r_pr;
        tab_ra = r_run_slot;
        rq_we  = 1'b0;
        rq_wd  = r_run_slot;
        div_start = 1'b0;
        div_dvd   = r_item.split_roll;
        div_dsr   = bud;
        case (i_cmd.op)
            OP_LOAD: begin
                tab_we = !load_full;
                tab_wa = r_next_id[AW-1:0];
                tab_wd = load_rec;
                rq_we  = !load_full;
                rq_wd  = r_next_id[AW-1:0];
            end
            OP_DISP: tab_ra = rq_rd;
            OP_CLATCH: div_start = r_disp && blk;
            OP_CEXEC: begin
                tab_we = 1'b1;
                tab_wd = cexec_rec;
                rq_we  = cx_rq;
            end
            OP_IOPOP: tab_ra = iq_rd;
            OP_IOSRD: tab_ra = r_io_slot;
            OP_ILATCH: begin
                div_start = r_io_new && (tab_p.cpu_left != 16'd0);
                div_dvd   = r_item.io_roll;
                div_dsr   = {8'd0, m8};
            end
            OP_ISERVE: begin
                tab_we = 1'b1;
                tab_wa = r_io_slot;
                tab_wd = serve_rec;
                rq_we  = sv_fin;
                rq_wd  = r_io_slot;
            end
            default: ;
        endcase
    end

    ctsched_ram #(.WIDTH($bits(t_proc)), .DEPTH(MAX_PROCS)) u_tab (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_wa), .i_wdata(tab_wd),
        .i_raddr(tab_ra), .o_rdata(tab_rd)
    );
    ctsched_ram #(.WIDTH(AW), .DEPTH(MAX_PROCS)) u_rq (
        .i_clk(i_clk), .i_we(rq_we), .i_waddr(rq_wa), .i_wdata(rq_wd),
        .i_raddr(r_rhead), .o_rdata(rq_rd)
    );
    ctsched_ram #(.WIDTH(AW), .DEPTH(MAX_PROCS)) u_iq (
        .i_clk(i_clk), .i_we(iq_we), .i_waddr(iq_wa), .i_wdata(iq_wd),
        .i_raddr(r_ihead), .o_rdata(iq_rd)
    );
    ctsched_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_dividend(div_dvd),
        .i_divisor(div_dsr), .o_busy(div_busy), .o_rem(div_rem)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rr         <= 1'b0;
            r_quantum    <= 8'd5;
            r_io_max     <= 8'd30;
            r_rhead      <= '0;
            r_ihead      <= '0;
            r_rcnt       <= '0;
            r_icnt       <= '0;
            r_next_id    <= '0;
            r_run_valid  <= 1'b0;
            r_io_valid   <= 1'b0;
            r_will_block <= 1'b0;
            r_io_wake    <= 1'b0;
            r_io_idle    <= 1'b0;
            r_disp       <= 1'b0;
            r_io_new     <= 1'b0;
            r_need       <= 1'b0;
            r_tick       <= 32'd1;
            r_res_valid  <= 1'b0;
            r_budget     <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RR_MODE: r_rr      <= i_cfg_data[0];
                    CFG_QUANTUM: r_quantum <= i_cfg_data;
                    CFG_IO_MAX:  r_io_max  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_res_valid && i_res_ready && (i_cmd.op != OP_FIN)) begin
                r_res_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    if (!load_full) begin
                        r_rcnt    <= r_rcnt + 1'b1;
                        r_next_id <= r_next_id + 1'b1;
                    end
                end
                OP_DISP: begin
                    r_rhead     <= f_wrap(CW'(r_rhead) + 1'b1);
                    r_rcnt      <= r_rcnt - 1'b1;
                    r_run_slot  <= rq_rd;
                    r_run_valid <= 1'b1;
                    r_disp      <= 1'b1;
                end
                OP_RUNRD: r_disp <= 1'b0;
                OP_CLATCH: begin
                    r_need <= r_disp && blk;
                    if (r_disp) begin
                        r_budget <= bud;
                        if (blk) begin
                            r_will_block <= 1'b1;
                        end
                    end
                end
                OP_CFIX: begin
                    if (r_need) begin
                        r_budget <= div_rem + 16'd1;
                    end
                end
                OP_CEXEC: begin
                    if (!cx_left_nz) begin
                        r_run_valid <= 1'b0;
                    end else begin
                        r_budget <= (r_budget != 16'd0) ? r_budget - 16'd1 : 16'd0;
                        if (cx_io) begin
                            r_io_wake    <= 1'b1;
                            r_icnt       <= r_icnt + 1'b1;
                            r_run_valid  <= 1'b0;
                            r_will_block <= 1'b0;
                        end else if (cx_rq) begin
                            r_rcnt      <= r_rcnt + 1'b1;
                            r_run_valid <= 1'b0;
                        end
                    end
                end
                OP_IOCHK: begin
                    if ((r_icnt == '0) && !r_io_valid) begin
                        r_io_idle <= 1'b1;
                    end else if (!r_io_valid && r_io_idle && r_io_wake) begin
                        // idle device waits one tick after a fresh block
                        r_io_idle <= 1'b0;
                        r_io_wake <= 1'b0;
                    end
                end
                OP_IOPOP: begin
                    r_ihead    <= f_wrap(CW'(r_ihead) + 1'b1);
                    r_icnt     <= r_icnt - 1'b1;
                    r_io_slot  <= iq_rd;
                    r_io_valid <= 1'b1;
                    r_io_new   <= 1'b1;
                end
                OP_IOSRD: r_io_new <= 1'b0;
                OP_ILATCH: r_need <= div_start;
                OP_ISERVE: begin
                    if (sv_fin) begin
                        r_io_idle  <= 1'b1;
                        r_rcnt     <= r_rcnt + 1'b1;
                        r_io_valid <= 1'b0;
                    end
                end
                OP_FIN: begin
                    r_res_valid <= 1'b1;
                    r_io_wake   <= 1'b0;
                    if (r_item.kind == KIND_TICK) begin
                        r_tick <= r_tick + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_TAKE: begin
                r_item <= i_item;
                r_work <= '0;
            end
            OP_LOAD: r_work.load_error <= load_full;
            OP_CLATCH: r_pr <= clatch_rec;
            OP_CEXEC: begin
                r_pr <= cexec_rec;
                if (!cx_left_nz) begin
                    r_work.done_valid      <= 1'b1;
                    r_work.done_id         <= 6'(r_run_slot);
                    r_work.done_time       <= r_tick;
                    r_work.done_dispatches <= r_pr.dispatch_count;
                    r_work.done_io_blocks  <= r_pr.io_block_count;
                    r_work.done_io_time    <= r_pr.io_total;
                end else begin
                    r_work.cpu_was_busy <= 1'b1;
                end
            end
            OP_ILATCH: r_pr <= tab_p;
            OP_IFIX: begin
                if (r_io_new) begin
                    r_pr.io_left        <= io_t;
                    r_pr.io_block_count <= r_pr.io_block_count + 16'd1;
                    r_pr.io_total       <= r_pr.io_total + {16'd0, io_t};
                end
            end
            OP_ISERVE: begin
                r_pr                <= serve_rec;
                r_work.io_was_busy  <= 1'b1;
            end
            OP_FIN: r_res <= fin_res;
            default: ;
        endcase
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    assign o_stat.kind      = r_item.kind;
    assign o_stat.run_valid = r_run_valid;
    assign o_stat.ready_nz  = (r_rcnt != '0);
    assign o_stat.io_nz     = (r_icnt != '0);
    assign o_stat.io_valid  = r_io_valid;
    assign o_stat.io_skip   = r_io_idle && r_io_wake;
    assign o_stat.div_busy  = div_busy;
    assign o_stat.out_free  = !r_res_valid || i_res_ready;

    assign procs_held = HW'(r_rcnt) + HW'(r_icnt) + HW'(r_run_valid) + HW'(r_io_valid);

    `CTS_NEVER(a_slot_clash, i_clk, i_rst_n, r_run_valid && r_io_valid && (r_run_slot == r_io_slot), "process held by cpu and io at once")
    `CTS_ASSERT(a_conserve, i_clk, i_rst_n, (procs_held <= HW'(r_next_id)), "more processes held than loaded")
    `CTS_NEVER(a_div_overlap, i_clk, i_rst_n, div_start && div_busy, "divider restarted while busy")
    `CTS_ASSERT(a_tick_step, i_clk, i_rst_n, ((i_cmd.op == OP_FIN) && (r_item.kind == KIND_TICK)) |=> (r_tick == $past(r_tick) + 32'd1), "tick counter did not advance")
endmodule

`default_nettype wire

// ===== hw/rtl/ctsched_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctsched_ctrl
// Sequencer for one request: load, or cpu step then io step of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ctsched_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ctsched_pkg::t_stat i_stat,
    output ctsched_pkg::t_cmd       o_cmd
);
    import ctsched_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_DEC    = 16'h0002,
        S_LOAD   = 16'h0004,
        S_T0     = 16'h0008,
        S_DISP   = 16'h0010,
        S_RUNRD  = 16'h0020,
        S_CLATCH = 16'h0040,
        S_CWAIT  = 16'h0080,
        S_CEXEC  = 16'h0100,
        S_IOCHK  = 16'h0200,
        S_IOPOP  = 16'h0400,
        S_IOSRD  = 16'h0800,
        S_ILATCH = 16'h1000,
        S_IWAIT  = 16'h2000,
        S_ISERVE = 16'h4000,
        S_FIN    = 16'h8000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_state  = S_DEC;
                end
            end
            S_DEC: n_state = (i_stat.kind == KIND_LOAD) ? S_LOAD : S_T0;
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = S_FIN;
            end
            S_T0: begin
                if (i_stat.run_valid) begin
                    n_state = S_RUNRD;
                end else if (i_stat.ready_nz) begin
                    n_state = S_DISP;
                end else begin
                    n_state = S_IOCHK;
                end
            end
            S_DISP: begin
                o_cmd.op = OP_DISP;
                n_state  = S_CLATCH;
            end
            S_RUNRD: begin
                o_cmd.op = OP_RUNRD;
                n_state  = S_CLATCH;
            end
            S_CLATCH: begin
                o_cmd.op = OP_CLATCH;
                n_state  = S_CWAIT;
            end
            S_CWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_CFIX;
                    n_state  = S_CEXEC;
                end
            end
            S_CEXEC: begin
                o_cmd.op = OP_CEXEC;
                n_state  = S_IOCHK;
            end
            S_IOCHK: begin
                o_cmd.op = OP_IOCHK;
                if (!i_stat.io_nz && !i_stat.io_valid) begin
                    n_state = S_FIN;
                end else if (!i_stat.io_valid) begin
                    n_state = i_stat.io_skip ? S_FIN : S_IOPOP;
                end else begin
                    n_state = S_IOSRD;
                end
            end
            S_IOPOP: begin
                o_cmd.op = OP_IOPOP;
                n_state  = S_ILATCH;
            end
            S_IOSRD: begin
                o_cmd.op = OP_IOSRD;
                n_state  = S_ILATCH;
            end
            S_ILATCH: begin
                o_cmd.op = OP_ILATCH;
                n_state  = S_IWAIT;
            end
            S_IWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_IFIX;
                    n_state  = S_ISERVE;
                end
            end
            S_ISERVE: begin
                o_cmd.op = OP_ISERVE;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_FIN;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

`default_nettype wire
